// ===== hw/rtl/flash_block_usage_classifier_macros.svh =====
// assertion macros used by the block's checker
`ifndef FLASH_BLOCK_USAGE_CLASSIFIER_MACROS_SVH
`define FLASH_BLOCK_USAGE_CLASSIFIER_MACROS_SVH

// concurrent assertion, switched off while reset is held
`define FBUC_ASSERT(name, clk, rstn, prop) \
  name: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("fbuc assertion failed");

// concurrent assertion that also holds during reset
`define FBUC_ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("fbuc assertion failed");

`endif

// ===== hw/rtl/fbuc_pkg.sv =====
// types and constants of the flash block usage classifier
package fbuc_pkg;

  // default number of blocks the position counter covers
  localparam int DEFAULT_MAX_BLOCKS = 4096;

  // width for position + run size and for the clamped block total
  localparam int SUM_W = 17;

  // result queue between classifier and output side
  localparam int FIFO_DEPTH = 4;

  // configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_BLOCKS  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DIR_MAGIC     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DIR_EXT_MAGIC = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FILE_MAGIC    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CONTENT_MAGIC = 3'd4;

  // usage classes
  localparam logic [2:0] CLASS_FREE = 3'd0;
  localparam logic [2:0] CLASS_USED = 3'd1;
  localparam logic [2:0] CLASS_DIR  = 3'd2;
  localparam logic [2:0] CLASS_FILE = 3'd3;
  localparam logic [2:0] CLASS_BAD  = 3'd4;

  localparam logic [15:0] ERASED_MAGIC = 16'hFFFF;

  // one header item
  typedef struct packed {
    logic [15:0] header_magic;
    logic [15:0] header_run;
  } in_item_t;

  // one classification result
  typedef struct packed {
    logic [11:0] block_number;
    logic [2:0]  usage_class;
    logic        final_block;
  } out_item_t;

endpackage

// ===== hw/rtl/fbuc_fifo.sv =====
// small result queue between the classifier and the output side
module fbuc_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  fbuc_pkg::out_item_t data_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              empty_o,
  output fbuc_pkg::out_item_t data_o
);
  import fbuc_pkg::*;

  localparam int PtrW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CntW = $clog2(FIFO_DEPTH + 1);

  out_item_t         mem_q [FIFO_DEPTH];
  logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]   count_q;
  logic              do_push, do_pop;

  assign full_o  = (count_q == CntW'(FIFO_DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  // storage, no reset needed
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

// ===== hw/rtl/fbuc_front.sv =====
// front end: configuration registers, scan state and per-block classification
module fbuc_front #(
  parameter int MAX_BLOCKS = fbuc_pkg::DEFAULT_MAX_BLOCKS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  input  logic [fbuc_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [15:0]                   cfg_data_i,
  input  logic                          accept_i,
  input  fbuc_pkg::in_item_t            item_i,
  output fbuc_pkg::out_item_t           result_o
);
  import fbuc_pkg::*;

  localparam int PosW = $clog2(MAX_BLOCKS);

  logic [12:0]      total_q;
  logic [15:0]      dir_magic_q, dir_ext_magic_q, file_magic_q, content_magic_q;
  logic [PosW-1:0]  pos_q;
  logic [15:0]      run_left_q;
  logic [2:0]       run_class_q;

  logic [SUM_W-1:0] tot_raw, tot_eff, max_ext, pos_ext, run_end, next_pos;
  logic [2:0]       magic_class, cls;
  logic             is_final, start_run;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q         <= 13'd4096;
      dir_magic_q     <= '0;
      dir_ext_magic_q <= '0;
      file_magic_q    <= '0;
      content_magic_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_TOTAL_BLOCKS:  total_q         <= cfg_data_i[12:0];
        CFG_DIR_MAGIC:     dir_magic_q     <= cfg_data_i;
        CFG_DIR_EXT_MAGIC: dir_ext_magic_q <= cfg_data_i;
        CFG_FILE_MAGIC:    file_magic_q    <= cfg_data_i;
        CFG_CONTENT_MAGIC: content_magic_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // clamp the block total into one to max blocks
  always_comb begin
    tot_raw = SUM_W'(total_q);
    max_ext = SUM_W'(MAX_BLOCKS);
    if (tot_raw == '0) begin
      tot_eff = SUM_W'(1);
    end else if (tot_raw > max_ext) begin
      tot_eff = max_ext;
    end else begin
      tot_eff = tot_raw;
    end
  end

  // magic lookup in priority order
  always_comb begin
    if (item_i.header_magic == dir_magic_q || item_i.header_magic == dir_ext_magic_q) begin
      magic_class = CLASS_DIR;
    end else if (item_i.header_magic == file_magic_q ||
                 item_i.header_magic == content_magic_q) begin
      magic_class = CLASS_FILE;
    end else begin
      magic_class = CLASS_BAD;
    end
  end

  // classify the current block
  always_comb begin
    pos_ext   = SUM_W'(pos_q);
    run_end   = pos_ext + SUM_W'(item_i.header_run);
    next_pos  = pos_ext + SUM_W'(1);
    is_final  = (next_pos >= tot_eff);
    start_run = 1'b0;
    if (pos_q == '0) begin
      cls = CLASS_USED;
    end else if (run_left_q != '0) begin
      cls = run_class_q;
    end else if (item_i.header_magic == ERASED_MAGIC) begin
      cls = CLASS_FREE;
    end else if (item_i.header_run == '0) begin
      cls = CLASS_BAD;
    end else if (run_end > tot_eff) begin
      cls = CLASS_BAD;
    end else begin
      cls       = magic_class;
      start_run = 1'b1;
    end
    result_o.block_number = pos_ext[11:0];
    result_o.usage_class  = cls;
    result_o.final_block  = is_final;
  end

  // scan state advances once per accepted item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      run_left_q  <= '0;
      run_class_q <= CLASS_FREE;
    end else if (accept_i) begin
      if (is_final) begin
        pos_q       <= '0;
        run_left_q  <= '0;
        run_class_q <= CLASS_FREE;
      end else begin
        pos_q <= pos_q + 1'b1;
        if (pos_q == '0) begin
          run_left_q <= '0;
        end else if (run_left_q != '0) begin
          run_left_q <= run_left_q - 16'd1;
        end else if (start_run) begin
          run_left_q  <= item_i.header_run - 16'd1;
          run_class_q <= magic_class;
        end
      end
    end
  end

endmodule

// ===== hw/rtl/flash_block_usage_classifier.sv =====
// top level of the flash block usage classifier
// Takes the first header word of each flash block in block order and returns one
// usage class per block (free, used, directory, file, bad) with its block number
// and a flag on the last block of the scan. One header is accepted per clock while
// full is low; the front end classifies it in the cycle it is pushed, so its result
// can be popped from the next cycle on. A four-item result queue separates the two
// sides, so full only rises once four results wait unpopped. Configuration writes
// are always ready and are registered; write them only while the block is idle.
module flash_block_usage_classifier #(
  parameter int MAX_BLOCKS = fbuc_pkg::DEFAULT_MAX_BLOCKS
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [fbuc_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [15:0]                    cfg_data_i,
  input  logic                           push,
  output logic                           full,
  input  fbuc_pkg::in_item_t             in_item_i,
  output logic                           empty,
  input  logic                           pop,
  output fbuc_pkg::out_item_t            out_item_o
);
  import fbuc_pkg::*;

  logic      accept;
  out_item_t result;

  assign cfg_ready_o = 1'b1;
  assign accept      = push && !full;

  // classifier front end
  fbuc_front #(
    .MAX_BLOCKS(MAX_BLOCKS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .accept_i   (accept),
    .item_i     (in_item_i),
    .result_o   (result)
  );

  // result queue toward the consumer
  fbuc_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (accept),
    .data_i (result),
    .full_o (full),
    .pop_i  (pop),
    .empty_o(empty),
    .data_o (out_item_o)
  );

endmodule

// ===== hw/rtl/fbuc_checker.sv =====
// port-level checker for the flash block usage classifier, with its bind
`include "flash_block_usage_classifier_macros.svh"

module fbuc_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           cfg_valid_i,
  input logic                           cfg_ready_o,
  input logic [fbuc_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input logic [15:0]                    cfg_data_i,
  input logic                           push,
  input logic                           full,
  input fbuc_pkg::in_item_t             in_item_i,
  input logic                           empty,
  input logic                           pop,
  input fbuc_pkg::out_item_t            out_item_o
);
  import fbuc_pkg::*;

  logic        seen_q;
  logic [11:0] last_num_q;
  logic        last_final_q;
  logic        popped;
  logic [11:0] expect_num;

  assign popped     = pop && !empty;
  assign expect_num = last_final_q ? 12'd0 : last_num_q + 12'd1;

  // remember the last result taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q       <= 1'b0;
      last_num_q   <= '0;
      last_final_q <= 1'b0;
    end else if (popped) begin
      seen_q       <= 1'b1;
      last_num_q   <= out_item_o.block_number;
      last_final_q <= out_item_o.final_block;
    end
  end

  // queue cannot be full and empty at once, trivially true while reset is held
  `FBUC_ASSERT_ALWAYS(a_full_empty, clk_i, (!rst_ni || !(full && empty)))

  // block numbers follow in scan order and wrap after the final block
  `FBUC_ASSERT(a_order, clk_i, rst_ni,
    (popped && seen_q) |-> (out_item_o.block_number == expect_num))

  // the block after a final block is the header block, always used
  `FBUC_ASSERT(a_first_used, clk_i, rst_ni,
    (popped && seen_q && last_final_q) |-> (out_item_o.usage_class == CLASS_USED))

  // a waiting result holds until taken
  `FBUC_ASSERT(a_hold, clk_i, rst_ni, (!empty && !pop) |=> $stable(out_item_o))

endmodule

bind flash_block_usage_classifier fbuc_checker u_fbuc_checker (.*);
